[hdl/wpir_pkg.sv]
// Shared types and constants for the windowed peak intensity rank core.
`default_nettype none
package wpir_pkg;

	localparam int MZ_W             = 32;
	localparam int INT_W            = 32;
	localparam int RANK_W           = 6;
	localparam int WINDOW_PEAKS_DEF = 32;
	localparam logic [MZ_W-1:0] HALF_WINDOW_RESET = 32'd3276800;

	// one stored peak
	typedef struct packed {
		logic [MZ_W-1:0]   mz;
		logic [INT_W-1:0]  inten;
		logic [RANK_W-1:0] rank;
		logic              valid;
	} wpir_cell_t;

	// incoming peak broadcast to every cell
	typedef struct packed {
		logic [MZ_W-1:0]   mz;
		logic [INT_W-1:0]  inten;
		logic [RANK_W-1:0] rank;
	} wpir_peak_t;

	typedef struct packed {
		logic compare;
		logic shift;
		logic insert;
	} wpir_cmd_t;

	// view of the chain head for the sequencer
	typedef struct packed {
		logic              head_valid;
		logic              head_closed;
		logic [RANK_W-1:0] head_rank;
		logic              next_valid;
		logic              next_closed;
		logic              full;
	} wpir_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_COUNT,
		ST_CLOSE,
		ST_FLUSH,
		ST_EVICT,
		ST_INSERT
	} wpir_state_t;

endpackage
`default_nettype wire

[hdl/windowed_peak_intensity_rank_core.sv]
// Top level of the windowed peak intensity rank core: config register, cell chain, sequencer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  peak in  | in_valid / in_ready  | peak_mz, peak_intensity, spectrum_end
//  rank out | out_valid/out_ready  | rank, truncated, spectrum_last, run_last
//  config   | cfg_we (no wait)     | cfg_wdata -> half window
//
//  One peak at a time: accept, a compare step (all cells in parallel), a count step that
//  sums the greater flags in 8-cell chunks until none are left, a close decision step,
//  the result beats (each waits for a free output), and an insert step for a stored
//  peak. A stored peak may release an evicted beat; the last peak of a spectrum flushes
//  the store and ends with its own beat.
//  Reset clears all cell valid bits and the sequencer; the half window returns to 50.0.
//  A stalled output holds the sequencer in its drain state; the chain waits with it.
`default_nettype none
module windowed_peak_intensity_rank_core #(
	parameter int WINDOW_PEAKS = wpir_pkg::WINDOW_PEAKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wpir_pkg::MZ_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wpir_pkg::MZ_W-1:0]     peak_mz,
	input  logic [wpir_pkg::INT_W-1:0]    peak_intensity,
	input  logic                          spectrum_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wpir_pkg::RANK_W-1:0]   rank,
	output logic                          truncated,
	output logic                          spectrum_last,
	output logic                          run_last
);
	import wpir_pkg::*;

	logic [MZ_W-1:0]         hwin_q;
	wpir_cmd_t               cmd;
	wpir_peak_t              peak;
	wpir_status_t            status;
	wpir_cell_t              cells [WINDOW_PEAKS];
	logic [WINDOW_PEAKS-1:0] gt;
	logic [WINDOW_PEAKS-1:0] closed;

	// half window, Q16.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwin_q <= HALF_WINDOW_RESET;
		end else if (cfg_we) begin
			hwin_q <= cfg_wdata;
		end
	end

	// cell 0 is the oldest peak; a shift moves every cell one place toward it
	for (genvar i = 0; i < WINDOW_PEAKS; i++) begin : g_cell
		wpir_cell_t nbr;
		logic       prev_valid;
		if (i == WINDOW_PEAKS - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cells[i+1];
		end
		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = cells[i-1].valid;
		end
		wpir_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.peak        (peak),
			.hwin        (hwin_q),
			.prev_valid  (prev_valid),
			.nbr         (nbr),
			.slot        (cells[i]),
			.gt          (gt[i]),
			.closed      (closed[i])
		);
	end

	// sequencer sees the first two cells of the chain, the full flag and every cell's gt flag
	assign status = '{
		head_valid:  cells[0].valid,
		head_closed: closed[0],
		head_rank:   cells[0].rank,
		next_valid:  cells[1].valid,
		next_closed: closed[1],
		full:        cells[WINDOW_PEAKS-1].valid
	};

	wpir_ctrl #(
		.WINDOW_PEAKS (WINDOW_PEAKS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.peak_mz        (peak_mz),
		.peak_intensity (peak_intensity),
		.spectrum_end   (spectrum_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.rank           (rank),
		.truncated      (truncated),
		.spectrum_last  (spectrum_last),
		.run_last       (run_last),
		.cmd            (cmd),
		.peak           (peak),
		.status         (status),
		.gt             (gt)
	);

endmodule
`default_nettype wire

[hdl/wpir_cell.sv]
// One window cell: holds a peak, compares it with the incoming one, shifts toward the head.
`default_nettype none
module wpir_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wpir_pkg::wpir_cmd_t      cmd,
	input  wpir_pkg::wpir_peak_t     peak,
	input  logic [wpir_pkg::MZ_W-1:0] hwin,
	input  logic                     prev_valid,
	input  wpir_pkg::wpir_cell_t     nbr,
	output wpir_pkg::wpir_cell_t     slot,
	output logic                     gt,
	output logic                     closed
);
	import wpir_pkg::*;

	logic              valid_q;
	logic [MZ_W-1:0]   mz_q;
	logic [INT_W-1:0]  inten_q;
	logic [RANK_W-1:0] rank_q;
	logic [MZ_W-1:0]   gap;
	logic              in_win;
	logic              take;

	assign gap    = (peak.mz >= mz_q) ? (peak.mz - mz_q) : (mz_q - peak.mz);
	assign in_win = valid_q && (gap <= hwin);
	assign gt     = in_win && (inten_q > peak.inten);
	assign closed = valid_q && (peak.mz > mz_q) && ((peak.mz - mz_q) > hwin);
	assign take   = cmd.insert && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (cmd.shift) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mz_q    <= peak.mz;
			inten_q <= peak.inten;
			rank_q  <= peak.rank;
		end else if (cmd.shift) begin
			mz_q    <= nbr.mz;
			inten_q <= nbr.inten;
			rank_q  <= nbr.rank;
		end else if (cmd.compare && in_win && (peak.inten > inten_q)) begin
			// saturating count
			rank_q <= (rank_q == {RANK_W{1'b1}}) ? rank_q : rank_q + 1'b1;
		end
	end

	assign slot = '{mz: mz_q, inten: inten_q, rank: rank_q, valid: valid_q};

endmodule
`default_nettype wire

[hdl/wpir_ctrl.sv]
// Sequencer: accepts peaks, counts the new rank, drains the chain head into the output register.
`default_nettype none
module wpir_ctrl #(
	parameter int WINDOW_PEAKS = wpir_pkg::WINDOW_PEAKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wpir_pkg::MZ_W-1:0]     peak_mz,
	input  logic [wpir_pkg::INT_W-1:0]    peak_intensity,
	input  logic                          spectrum_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wpir_pkg::RANK_W-1:0]   rank,
	output logic                          truncated,
	output logic                          spectrum_last,
	output logic                          run_last,
	output wpir_pkg::wpir_cmd_t           cmd,
	output wpir_pkg::wpir_peak_t          peak,
	input  wpir_pkg::wpir_status_t        status,
	input  logic [WINDOW_PEAKS-1:0]       gt
);
	import wpir_pkg::*;

	localparam int NCHUNK = (WINDOW_PEAKS + 7) / 8;
	localparam int PAD_W  = NCHUNK * 8;

	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] s;
		s = 4'd0;
		for (int i = 0; i < 8; i++) s = s + {3'd0, v[i]};
		return s;
	endfunction

	wpir_state_t       state_q, state_d;
	logic [MZ_W-1:0]   mz_q;
	logic [INT_W-1:0]  inten_q;
	logic              last_q;
	logic [RANK_W-1:0] acc_q;
	logic [PAD_W-1:0]  gt_q;

	logic              out_free;
	logic              out_load;
	logic [RANK_W-1:0] rank_d;
	logic              trunc_d, slast_d, rlast_d;
	logic              out_valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              trunc_q, slast_q, rlast_q;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign peak     = '{mz: mz_q, inten: inten_q, rank: acc_q};

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		rank_d   = status.head_rank;
		trunc_d  = 1'b0;
		slast_d  = 1'b0;
		rlast_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_COMPARE;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = ST_COUNT;
			end
			ST_COUNT: begin
				if (gt_q == '0) state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				if (status.head_valid && status.head_closed) begin
					if (out_free) begin
						out_load  = 1'b1;
						cmd.shift = 1'b1;
						rlast_d   = !last_q && !(status.next_valid && status.next_closed);
					end
				end else if (last_q) begin
					state_d = ST_FLUSH;
				end else if (status.full) begin
					state_d = ST_EVICT;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (status.head_valid) begin
						cmd.shift = 1'b1;
					end else begin
						// the closing peak itself
						rank_d  = acc_q;
						slast_d = 1'b1;
						rlast_d = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_EVICT: begin
				if (out_free) begin
					out_load  = 1'b1;
					cmd.shift = 1'b1;
					trunc_d   = 1'b1;
					rlast_d   = 1'b1;
					state_d   = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mz_q    <= peak_mz;
			inten_q <= peak_intensity;
			last_q  <= spectrum_end;
		end
		if (state_q == ST_COMPARE) begin
			gt_q  <= PAD_W'(gt);
			acc_q <= '0;
		end else if (state_q == ST_COUNT && gt_q != '0) begin
			acc_q <= acc_q + RANK_W'(popcnt8(gt_q[7:0]));
			gt_q  <= gt_q >> 8;
		end
		if (out_load) begin
			rank_q  <= rank_d;
			trunc_q <= trunc_d;
			slast_q <= slast_d;
			rlast_q <= rlast_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign rank          = rank_q;
	assign truncated     = trunc_q;
	assign spectrum_last = slast_q;
	assign run_last      = rlast_q;

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.compare, cmd.shift, cmd.insert}))
		else $error("cell commands overlap");

	a_shift_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> out_load)
		else $error("chain shifted without an output beat");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !status.full)
		else $error("insert into a full window");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (trunc_q || slast_q)) |-> rlast_q)
		else $error("evicted or closing beat not marked run_last");

endmodule
`default_nettype wire

[test/wpir_rank_checker.sv]
// Checker for the peak rank core: mirrors the window store, predicts every rank beat, compares.
`default_nettype none
module wpir_rank_checker #(
	parameter int WINDOW_PEAKS = wpir_pkg::WINDOW_PEAKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wpir_pkg::MZ_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [wpir_pkg::MZ_W-1:0]   peak_mz,
	input  logic [wpir_pkg::INT_W-1:0]  peak_intensity,
	input  logic                        spectrum_end,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [wpir_pkg::RANK_W-1:0] rank,
	input  logic                        truncated,
	input  logic                        spectrum_last,
	input  logic                        run_last,
	output int                          mismatches,
	output int                          ranks_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import wpir_pkg::*;

	localparam logic [RANK_W-1:0] RANK_TOP = '1;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              truncated;
		logic              spectrum_last;
		logic              run_last;
	} rank_beat_t;

	logic [MZ_W-1:0]   half_win;
	logic [MZ_W-1:0]   win_mz    [WINDOW_PEAKS];
	logic [INT_W-1:0]  win_inten [WINDOW_PEAKS];
	logic [RANK_W-1:0] win_rank  [WINDOW_PEAKS];
	logic              win_trunc [WINDOW_PEAKS];
	int                win_count;
	rank_beat_t        rank_due [$];
	int                fails = 0;
	int                due_count = 0;

	assign mismatches = fails;
	assign ranks_due  = due_count;

	function automatic logic [RANK_W-1:0] bump(input logic [RANK_W-1:0] r);
		return (r == RANK_TOP) ? r : r + 1'b1;
	endfunction

	// signed distance of two unsigned Q16.16 positions
	function automatic longint mz_gap(input logic [MZ_W-1:0] a, input logic [MZ_W-1:0] b);
		longint sa;
		longint sb;
		sa = longint'(a);
		sb = longint'(b);
		return sa - sb;
	endfunction

	function automatic rank_beat_t make_beat(input logic [RANK_W-1:0] r, input logic t,
						 input logic s);
		rank_beat_t b;
		b.rank          = r;
		b.truncated     = t;
		b.spectrum_last = s;
		b.run_last      = 1'b0;
		return b;
	endfunction

	task automatic pop_oldest();
		for (int i = 0; i < win_count - 1; i++) begin
			win_mz[i]    = win_mz[i+1];
			win_inten[i] = win_inten[i+1];
			win_rank[i]  = win_rank[i+1];
			win_trunc[i] = win_trunc[i+1];
		end
		win_count--;
	endtask

	// ranks the new peak against the store and queues every beat it releases
	task automatic rank_peak(input logic [MZ_W-1:0] mz, input logic [INT_W-1:0] inten,
				 input logic last);
		logic [RANK_W-1:0] new_rank;
		longint            hw;
		longint            gap;
		rank_beat_t        beats [$];
		new_rank = '0;
		hw = longint'(half_win);
		for (int c = 0; c < win_count; c++) begin
			gap = mz_gap(mz, win_mz[c]);
			if (gap <= hw && gap >= -hw) begin
				if (win_inten[c] > inten)
					new_rank = bump(new_rank);
				else if (inten > win_inten[c])
					win_rank[c] = bump(win_rank[c]);
			end
		end
		// closed peaks leave from the head only
		while (win_count > 0 && mz_gap(mz, win_mz[0]) > hw) begin
			beats.insert(beats.size(), make_beat(win_rank[0], win_trunc[0], 1'b0));
			pop_oldest();
		end
		if (last) begin
			for (int c = 0; c < win_count; c++)
				beats.insert(beats.size(), make_beat(win_rank[c], win_trunc[c], 1'b0));
			win_count = 0;
			beats.insert(beats.size(), make_beat(new_rank, 1'b0, 1'b1));
		end else begin
			if (win_count >= WINDOW_PEAKS) begin
				win_trunc[0] = 1'b1;
				beats.insert(beats.size(), make_beat(win_rank[0], 1'b1, 1'b0));
				pop_oldest();
			end
			win_mz[win_count]    = mz;
			win_inten[win_count] = inten;
			win_rank[win_count]  = new_rank;
			win_trunc[win_count] = 1'b0;
			win_count++;
		end
		if (beats.size() > 0)
			beats[beats.size()-1].run_last = 1'b1;
		foreach (beats[i])
			rank_due.insert(rank_due.size(), beats[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
				   input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_beat_t e;
		if (!arst_n) begin
			half_win  = HALF_WINDOW_RESET;
			win_count = 0;
			rank_due.delete();
			due_count = 0;
		end else begin
			// output first: a beat can never belong to a peak taken at the same edge
			if (out_valid && out_ready) begin
				if (rank_due.size() == 0) begin
					$error("rank beat with nothing expected: rank %0d", rank);
					fails++;
				end else begin
					e = rank_due.pop_front();
					check_field("rank", 32'(e.rank), 32'(rank));
					check_field("truncated", 32'(e.truncated), 32'(truncated));
					check_field("spectrum_last", 32'(e.spectrum_last),
						    32'(spectrum_last));
					check_field("run_last", 32'(e.run_last), 32'(run_last));
				end
			end
			if (cfg_we)
				half_win = cfg_wdata;
			if (in_valid && in_ready)
				rank_peak(peak_mz, peak_intensity, spectrum_end);
			due_count = rank_due.size();
		end
	end

endmodule
`default_nettype wire

[test/tb_windowed_peak_intensity_rank_core.sv]
// Testbench top for the windowed peak intensity rank core: stimulus, back-pressure, verdict.
`default_nettype none
module tb_windowed_peak_intensity_rank_core;
	timeunit 1ns;
	timeprecision 1ps;
	import wpir_pkg::*;

	localparam int     PEAKS       = WINDOW_PEAKS_DEF;
	// compare + rank chunks + a full flush of beats, with margin
	localparam int     SETTLE      = 64;
	localparam int     PHASES      = 6;
	localparam int     PHASE_ITEMS = 50;
	localparam int     HOLD_CYCLES = 400;
	// far beyond the slowest legal run
	localparam longint LIMIT_NS    = 1_000_000;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_we         = 1'b0;
	logic [MZ_W-1:0]     cfg_wdata      = '0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [MZ_W-1:0]     peak_mz        = '0;
	logic [INT_W-1:0]    peak_intensity = '0;
	logic                spectrum_end   = 1'b0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [RANK_W-1:0]   rank;
	logic                truncated;
	logic                spectrum_last;
	logic                run_last;

	int mismatches;
	int ranks_due;

	// idle odds in percent, changed per phase by the stimulus
	int send_idle_pct = 13;
	int recv_idle_pct = 77;
	// long receiver hold-off: stimulus bumps hold_ask, the receiver process counts it out
	int hold_ask  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int phase_sent;

	always #2 clk = ~clk;

	windowed_peak_intensity_rank_core #(
		.WINDOW_PEAKS(PEAKS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.peak_mz       (peak_mz),
		.peak_intensity(peak_intensity),
		.spectrum_end  (spectrum_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rank          (rank),
		.truncated     (truncated),
		.spectrum_last (spectrum_last),
		.run_last      (run_last)
	);

	wpir_rank_checker #(
		.WINDOW_PEAKS(PEAKS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.peak_mz       (peak_mz),
		.peak_intensity(peak_intensity),
		.spectrum_end  (spectrum_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rank          (rank),
		.truncated     (truncated),
		.spectrum_last (spectrum_last),
		.run_last      (run_last),
		.mismatches    (mismatches),
		.ranks_due     (ranks_due)
	);

	// receiver: random ready, or a counted hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one peak beat; valid stays up with a steady payload until the core takes it.
	// Returns right after the accepting edge, leaving valid up for a back-to-back beat.
	task automatic send_peak(input logic [MZ_W-1:0] mz, input logic [INT_W-1:0] inten,
				 input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		peak_mz        <= mz;
		peak_intensity <= inten;
		spectrum_end   <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		phase_sent++;
	endtask

	// sender goes quiet until every expected rank is back, then lets the core finish
	// any peak that released nothing
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ranks_due != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_half_window(input logic [MZ_W-1:0] hw);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= hw;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ascending run of peaks; steps straddle the window edge so peaks close, stay
	// open, or tie on m/z. closed = 0 leaves the spectrum open in the store.
	task automatic send_spectrum(input int len, input bit closed, input logic [MZ_W-1:0] hw);
		longint unsigned pos;
		longint unsigned step;
		longint unsigned span;
		logic [INT_W-1:0] inten;
		pos  = ($urandom_range(3) == 0) ? 0 : $urandom;
		span = hw;
		span = span + 1;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(4))
				0: step = 0;
				1: step = $urandom_range(255);
				2: begin
					step = $urandom;
					step = step % span;
				end
				3: step = hw;
				default: step = span;
			endcase
			if (i == 0)
				step = 0;
			pos = pos + step;
			if (pos > 64'hFFFF_FFFF)
				pos = 64'hFFFF_FFFF;
			// a quarter of the time from a tiny set so ties are frequent
			inten = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
			send_peak(pos[MZ_W-1:0], inten, closed && (i == len - 1));
		end
	endtask

	// all peaks at one m/z, one weak peak in the middle: store overflows, evicted
	// peaks carry truncated, and the weak one climbs to the top rank before eviction
	task automatic send_crowd();
		logic [MZ_W-1:0] mz;
		mz = $urandom;
		for (int i = 0; i < 2 * PEAKS + 6; i++) begin
			if (i == PEAKS)
				send_peak(mz, '0, 1'b0);
			else
				send_peak(mz, $urandom_range(32'hFFFF_FFFF, 1), i == 2 * PEAKS + 5);
		end
	endtask

	initial begin
		logic [MZ_W-1:0] hw;
		bit paused;
		phase_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default window of 50.0 first
		send_peak(32'd0, 32'd0, 1'b0);
		send_peak(32'd0, 32'hFFFF_FFFF, 1'b0);               // same m/z, stronger
		send_peak(HALF_WINDOW_RESET, 32'hAAAA_AAAA, 1'b0);   // exactly on the window edge
		send_peak(HALF_WINDOW_RESET + 1, 32'h5555_5555, 1'b0); // just past: first two close
		send_peak(HALF_WINDOW_RESET + 1, 32'h5555_5555, 1'b0); // equal intensity, no rank
		send_peak(32'd100, 32'd7, 1'b0);                     // m/z going backwards
		send_peak(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);       // far peak closes all, ends
		send_peak(32'h1234_5678, 32'd0, 1'b1);               // one-peak spectrum

		// zero window: only identical m/z are neighbors
		write_half_window('0);
		send_peak(32'd1000, 32'd10, 1'b0);
		send_peak(32'd1000, 32'd20, 1'b0);
		send_peak(32'd1001, 32'd5, 1'b0);
		send_peak(32'd1001, 32'd5, 1'b1);

		// widest window: everything is a neighbor, nothing ever closes
		write_half_window('1);
		send_peak(32'd0, 32'd1, 1'b0);
		send_peak(32'hFFFF_FFFF, 32'd2, 1'b0);
		send_peak(32'd0, 32'd3, 1'b0);
		send_peak(32'h8000_0000, 32'd0, 1'b1);

		// a closed peak stuck behind an older open one keeps its place
		write_half_window(32'd100);
		send_peak(32'd500, 32'd1, 1'b0);
		send_peak(32'd100, 32'd2, 1'b0);
		send_peak(32'd250, 32'd3, 1'b1);

		// random phases: window setting per phase, idle pattern per pair of phases
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (ph)
				0: hw = HALF_WINDOW_RESET;
				1: hw = '0;
				2: hw = '1;
				3: hw = $urandom_range(32'h0004_0000, 1);
				4: hw = $urandom;
				default: hw = $urandom_range(255, 1);
			endcase
			write_half_window(hw);
			phase_sent = 0;
			paused = 0;
			// the core backs up behind a stalled output while peaks keep coming
			if (ph == 1)
				hold_ask++;
			if (ph == 0)
				send_crowd();
			while (phase_sent < PHASE_ITEMS) begin
				if (ph == 3 && !paused && phase_sent > PHASE_ITEMS / 2) begin
					settle();
					paused = 1;
				end
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: begin
						if ($urandom_range(7) == 0)
							send_spectrum($urandom_range(45, 30), 1'b1, hw);
						else
							send_spectrum($urandom_range(12, 1), 1'b1, hw);
					end
					6, 7: send_peak($urandom, $urandom, $urandom_range(3) == 0);
					8: send_spectrum($urandom_range(6, 1), 1'b0, hw);
					default: send_peak($urandom, $urandom, 1'b1);
				endcase
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
